>>> hdl/differential_drive_odometry_assert.svh
// assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define DDO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define DDO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DDO_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// types and constants for the odometry top level, front end and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;
	localparam logic [31:0] DIST_RESET = 32'd2672758;
	localparam logic [31:0] HEAD_RESET = 32'd2534368870;
	localparam logic [29:0] INV_GAIN   = 30'd652032874;
	localparam logic REG_DIST = 1'b0;
	localparam logic REG_HEAD = 1'b1;

	// classified item handed from front end to back end
	typedef struct packed {
		logic signed [32:0] dsum;   // dL + dR
		logic signed [32:0] ddiff;  // dR - dL
		logic signed [24:0] ssum;   // ls + rs
		logic signed [24:0] sdiff;  // rs - ls
	} job_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051D;
				5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
				5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
				5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
				5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2E;
				5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
				5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
				5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
				5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
				5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
				5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
				5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

>>> hdl/ddo_front.sv
// ----------------------------------------------------------------------------
// ddo_front
// accepts encoder beats, forms wrapped deltas, sums and differences, keeps the last counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ddo_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        lc,
	input  wire logic [31:0]        rc,
	input  wire logic [23:0]        ls,
	input  wire logic [23:0]        rs,
	output logic                    job_valid,
	input  wire logic               job_ready,
	output ddo_pkg::job_t           job
);
	import ddo_pkg::*;
	logic [31:0] prev_l_q, prev_r_q;
	logic signed [31:0] dl, dr;
	job_t q0_q, q1_q;
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic push, pop;

	assign dl = lc - prev_l_q;
	assign dr = rc - prev_r_q;
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid && job_ready;
	assign job = rd_q ? q1_q : q0_q;

	// two-entry queue towards the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				prev_l_q <= lc;
				prev_r_q <= rc;
				wr_q <= ~wr_q;
			end
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (wr_q) begin
				q1_q.dsum  <= 33'(dl) + 33'(dr);
				q1_q.ddiff <= 33'(dr) - 33'(dl);
				q1_q.ssum  <= 25'(signed'(ls)) + 25'(signed'(rs));
				q1_q.sdiff <= 25'(signed'(rs)) - 25'(signed'(ls));
			end else begin
				q0_q.dsum  <= 33'(dl) + 33'(dr);
				q0_q.ddiff <= 33'(dr) - 33'(dl);
				q0_q.ssum  <= 25'(signed'(ls)) + 25'(signed'(rs));
				q0_q.sdiff <= 25'(signed'(rs)) - 25'(signed'(ls));
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/ddo_back.sv
// ----------------------------------------------------------------------------
// ddo_back
// scales deltas and speeds, runs the iterative cordic twice and updates pose and velocity
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "differential_drive_odometry_assert.svh"
module ddo_back #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   dist_per_tick,
	input  wire logic [31:0]   heading_per_tick,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  ddo_pkg::job_t      job,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [47:0]        pos_x,
	output logic [47:0]        pos_y,
	output logic [31:0]        heading,
	output logic [47:0]        vel_x,
	output logic [47:0]        vel_y,
	output logic [47:0]        turn_rate
);
	import ddo_pkg::*;
	localparam int SW = $clog2(CORDIC_STEPS + 1);
	localparam logic [31:0] KEEP = 32'(~((33'd1 << (32 - ANGLE_BITS)) - 33'd1));

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_RND, S_PRE1, S_PRE2, S_PRE3, S_ROT, S_DONE, S_OUT
	} st_t;
	st_t st_q;
	logic pass_q;                 // 0: position move, 1: velocity
	logic [2:0] sel_q;            // which scale job
	logic [SW-1:0] step_q;
	job_t job_q;
	logic [47:0] px_q, py_q, vx_q, vy_q, tr_q;
	logic [31:0] hd_q, dhead_q;
	logic signed [47:0] dist_q, fwd_q;
	// scale unit
	logic sgn_q;
	logic [63:0] prod_q;
	logic [32:0] mag_a;
	logic [31:0] mul_k;
	logic [4:0] sh;
	logic signed [47:0] rnd;
	logic signed [32:0] sa;
	// cordic
	logic signed [49:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [47:0] vmag_q;
	logic vneg_q;
	logic [63:0] pa_q, pb_q;
	logic [31:0] ang;
	logic [4:0] si;
	logic signed [49:0] xs, ys;
	logic [31:0] at;

	// scale operand selection: dist, dhead, fwd, turn
	always_comb begin
		case (sel_q)
			3'd0: sa = job_q.dsum;
			3'd1: sa = job_q.ddiff;
			3'd2: sa = 33'(job_q.ssum);
			default: sa = 33'(job_q.sdiff);
		endcase
		mul_k = sel_q[0] ? heading_per_tick : dist_per_tick;
		sh = sel_q[0] ? 5'd16 : 5'd17;
		mag_a = sa[32] ? 33'(-sa) : 33'(sa);
		rnd = 48'((prod_q + (64'd1 << (sh - 5'd1))) >> sh);
		ang = (pass_q ? hd_q : hd_q) & KEEP;
		si = 5'(step_q);
		xs = x_q >>> si;
		ys = y_q >>> si;
		at = atan_turn(si);
	end

	assign job_ready = (st_q == S_IDLE);
	assign res_valid = (st_q == S_OUT);
	assign pos_x = px_q;
	assign pos_y = py_q;
	assign heading = hd_q;
	assign vel_x = vx_q;
	assign vel_y = vy_q;
	assign turn_rate = tr_q;

	// sequencer: four scale jobs, then two cordic rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pass_q <= 1'b0;
			sel_q <= '0;
			step_q <= '0;
			job_q <= '0;
			px_q <= '0;
			py_q <= '0;
			hd_q <= '0;
			vx_q <= '0;
			vy_q <= '0;
			tr_q <= '0;
			dhead_q <= '0;
			dist_q <= '0;
			fwd_q <= '0;
			sgn_q <= 1'b0;
			prod_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			vmag_q <= '0;
			vneg_q <= 1'b0;
			pa_q <= '0;
			pb_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (job_valid) begin
					job_q <= job;
					sel_q <= '0;
					st_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= 64'(mag_a) * 64'(mul_k);
					sgn_q <= sa[32];
					st_q <= S_RND;
				end
				S_RND: begin
					case (sel_q)
						3'd0: dist_q <= sgn_q ? -rnd : rnd;
						3'd1: dhead_q <= 32'(sgn_q ? -rnd : rnd);
						3'd2: fwd_q <= sgn_q ? -rnd : rnd;
						default: tr_q <= sgn_q ? -rnd : rnd;
					endcase
					if (sel_q == 3'd3) begin
						pass_q <= 1'b0;
						st_q <= S_PRE1;
					end else begin
						sel_q <= sel_q + 3'd1;
						st_q <= S_MUL;
					end
				end
				S_PRE1: begin
					vneg_q <= pass_q ? fwd_q[47] : dist_q[47];
					vmag_q <= pass_q ? (fwd_q[47] ? -fwd_q : fwd_q)
						: (dist_q[47] ? -dist_q : dist_q);
					st_q <= S_PRE2;
				end
				S_PRE2: begin
					pa_q <= 64'(vmag_q[47:16]) * 64'(INV_GAIN);
					pb_q <= 64'(vmag_q[15:0]) * 64'(INV_GAIN) + (64'd1 << 29);
					st_q <= S_PRE3;
				end
				S_PRE3: begin
					logic [63:0] r;
					logic signed [49:0] xv;
					r = (pa_q + (pb_q >> 16)) >> 14;
					xv = vneg_q ? -50'(r) : 50'(r);
					if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
						x_q <= -xv;
						z_q <= 33'(signed'(ang + 32'h80000000));
					end else begin
						x_q <= xv;
						z_q <= 33'(signed'(ang));
					end
					y_q <= '0;
					step_q <= '0;
					st_q <= S_ROT;
				end
				S_ROT: begin
					if (!z_q[32]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 33'(at);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 33'(at);
					end
					if (step_q == SW'(CORDIC_STEPS - 1)) st_q <= S_DONE;
					step_q <= step_q + SW'(1);
				end
				S_DONE: begin
					if (!pass_q) begin
						px_q <= px_q + 48'(x_q);
						py_q <= py_q + 48'(y_q);
						hd_q <= hd_q + dhead_q;
						pass_q <= 1'b1;
						st_q <= S_PRE1;
					end else begin
						vx_q <= 48'(x_q);
						vy_q <= 48'(y_q);
						st_q <= S_OUT;
					end
				end
				S_OUT: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`DDO_ASSERT_IMP(a_no_take_busy, clk, arst_n, st_q != S_IDLE, !job_ready)
	`DDO_ASSERT_NXT(a_out_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(px_q))
	`DDO_ASSERT_IMP(a_step_range, clk, arst_n, st_q == S_ROT, step_q < SW'(CORDIC_STEPS))
endmodule
`default_nettype wire

>>> hdl/differential_drive_odometry.sv
// The back end takes a new item only after the last result has been taken, as the
// shared iterative cordic runs two rotations per item; a two-beat queue
// decouples the input side.
// Reset: arst_n clears pose, last counts and queue; registers take reset values.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// dead-reckoning odometry top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// left ticks, right ticks, left speed, right speed
	input  wire logic [111:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// pos_x, pos_y, heading, vel_x, vel_y, turn_rate
	output logic [271:0]      m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import ddo_pkg::*;
	logic [31:0] dpt_q, hpt_q;
	logic jv, jr;
	job_t jb;
	logic [47:0] px, py, vx, vy, tr;
	logic [31:0] hd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= DIST_RESET;
			hpt_q <= HEAD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_DIST) dpt_q <= cfg_data;
			else hpt_q <= cfg_data;
		end
	end

	ddo_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.lc(s_axis_tdata[31:0]), .rc(s_axis_tdata[63:32]),
		.ls(s_axis_tdata[87:64]), .rs(s_axis_tdata[111:88]),
		.job_valid(jv), .job_ready(jr), .job(jb)
	);

	ddo_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.dist_per_tick(dpt_q), .heading_per_tick(hpt_q),
		.job_valid(jv), .job_ready(jr), .job(jb),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.pos_x(px), .pos_y(py), .heading(hd), .vel_x(vx), .vel_y(vy), .turn_rate(tr)
	);

	assign m_axis_tdata = {tr, vy, vx, hd, py, px};
endmodule
`default_nettype wire
